FILE: rtl/core/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is high.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: rtl/core/sto_pkg.sv
package sto_pkg;

  localparam int QUEUE_DEPTH_DEF = 16;
  localparam int DL_W    = 32;
  localparam int ROUTE_W = 8;
  localparam int DELAY_W = 16;
  localparam int TPS_W   = 16;

  localparam logic [DL_W-1:0]  SIGN_BIT  = 32'h8000_0000;
  localparam logic [TPS_W-1:0] TPS_RESET = 16'd1000;

  // register index of ticks_per_second (byte address 4*index)
  localparam logic REG_TPS = 1'b0;

  typedef enum logic [1:0] {
    OP_ADD    = 2'd0,
    OP_CANCEL = 2'd1,
    OP_TICK   = 2'd2,
    OP_POLL   = 2'd3
  } timer_op_t;

  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE
  } cell_op_t;

  typedef struct packed {
    logic               valid;
    logic [DL_W-1:0]    deadline;
    logic [ROUTE_W-1:0] route;
  } cell_data_t;

  // broadcast to every cell of the row
  typedef struct packed {
    cell_op_t           op;
    logic [DL_W-1:0]    deadline;
    logic [ROUTE_W-1:0] route;
    logic               match_en;
    logic               force_head;
  } cell_ctrl_t;

  typedef struct packed {
    cell_data_t head;
    logic       full;
    logic       any_match;
  } chain_stat_t;

  // wraparound "a is earlier than b"
  function automatic logic is_earlier(input logic [DL_W-1:0] a, input logic [DL_W-1:0] b);
    logic [DL_W-1:0] diff;
    diff = a - b;
    return (diff & SIGN_BIT) != '0;
  endfunction

endpackage

FILE: rtl/core/sto_cell.sv
module sto_cell import sto_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cell_ctrl_t  ctrl,
  input  cell_data_t  left,
  input  cell_data_t  right,
  input  logic        before_in,
  input  logic        seen_in,
  output logic        before_out,
  output logic        seen_out,
  output cell_data_t  q
);

  logic               valid;
  logic [DL_W-1:0]    deadline;
  logic [ROUTE_W-1:0] route;
  cell_data_t         cur;
  cell_data_t         cur_next;
  logic               earlier;
  logic               match;

  assign cur = '{valid: valid, deadline: deadline, route: route};
  assign q   = cur;

  always_comb begin
    earlier    = valid && is_earlier(deadline, ctrl.deadline);
    before_out = before_in && earlier;
    match      = ctrl.match_en && valid && (route == ctrl.route);
    seen_out   = seen_in || match;
  end

  always_comb begin
    cur_next = cur;
    unique case (ctrl.op)
      CELL_INSERT: begin
        // cells past the insert point shift one place toward the tail
        if (!before_out) begin
          if (before_in) begin
            cur_next = '{valid: 1'b1, deadline: ctrl.deadline, route: ctrl.route};
          end else begin
            cur_next = left;
          end
        end
      end
      CELL_REMOVE: begin
        // from the first removed cell on, pull from the tail side
        if (seen_out) begin
          cur_next = right;
        end
      end
      default: cur_next = cur;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else begin
      valid <= cur_next.valid;
    end
  end

  always_ff @(posedge clk) begin
    deadline <= cur_next.deadline;
    route    <= cur_next.route;
  end

endmodule

FILE: rtl/core/sto_chain.sv
module sto_chain import sto_pkg::*; #(
  parameter int DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  cell_ctrl_t  ctrl,
  output chain_stat_t stat
);

  cell_data_t       cell_q [DEPTH];
  logic [DEPTH:0]   ahead;
  logic [DEPTH:0]   seen;

  assign ahead[0] = 1'b1;
  assign seen[0]  = ctrl.force_head;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cell_data_t left;
    cell_data_t right;

    if (i == 0) begin : g_first
      assign left = '0;
    end else begin : g_left
      assign left = cell_q[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign right = '0;
    end else begin : g_right
      assign right = cell_q[i+1];
    end

    sto_cell u_cell (
      .clk        (clk),
      .rst        (rst),
      .ctrl       (ctrl),
      .left       (left),
      .right      (right),
      .before_in  (ahead[i]),
      .seen_in    (seen[i]),
      .before_out (ahead[i+1]),
      .seen_out   (seen[i+1]),
      .q          (cell_q[i])
    );
  end

  assign stat.head      = cell_q[0];
  assign stat.full      = cell_q[DEPTH-1].valid;
  assign stat.any_match = seen[DEPTH];

endmodule

FILE: rtl/core/sorted_timeout_queue_core.sv
// Sorted timer queue: a row of cells kept in deadline order, head in cell 0.
// Add: multiply, deadline add, then insert, before the next accept.
// Tick and poll: head expiry check and pop of an expired head; tick first advances now_ticks.
// Cancel: matching entries are removed one per cycle, until a pass finds none.
// Result strobe done is high for one cycle, in the cycle busy drops; never held off.
// Synchronous reset: queue empty, now_ticks zero, ticks_per_second 1000.
module sorted_timeout_queue_core import sto_pkg::*; #(
  parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic [1:0]         op,
  input  logic [DELAY_W-1:0] delay_seconds,
  input  logic [ROUTE_W-1:0] route,
  output logic               done,
  output logic               fired,
  output logic [ROUTE_W-1:0] fired_route,
  output logic               status,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_DEADLINE,
    S_INSERT,
    S_CANCEL,
    S_EXPIRE
  } state_t;

  state_t             state;
  logic [DL_W-1:0]    now_ticks;
  logic [TPS_W-1:0]   ticks_per_second;
  logic [DL_W-1:0]    prod;
  logic [DL_W-1:0]    deadline;
  logic [ROUTE_W-1:0] route_q;

  cell_ctrl_t         ctrl;
  chain_stat_t        stat;
  logic               accept;
  logic               head_expired;
  logic [DL_W-1:0]    age;

  assign accept = start && !busy;
  assign busy   = (state != S_IDLE);

  // config port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_TPS) ? {16'b0, ticks_per_second} : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_second <= TPS_RESET;
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_TPS) begin
      ticks_per_second <= pwdata[TPS_W-1:0];
    end
  end

  always_comb begin
    age          = now_ticks - stat.head.deadline;
    head_expired = stat.head.valid && ((age & SIGN_BIT) == '0);
  end

  always_comb begin
    ctrl            = '0;
    ctrl.op         = CELL_HOLD;
    ctrl.deadline   = deadline;
    ctrl.route      = route_q;
    unique case (state)
      S_INSERT: begin
        if (!stat.full) begin
          ctrl.op = CELL_INSERT;
        end
      end
      S_CANCEL: begin
        ctrl.op       = CELL_REMOVE;
        ctrl.match_en = 1'b1;
      end
      S_EXPIRE: begin
        ctrl.op         = CELL_REMOVE;
        ctrl.force_head = head_expired;
      end
      default: ctrl.op = CELL_HOLD;
    endcase
  end

  sto_chain #(
    .DEPTH (QUEUE_DEPTH)
  ) u_chain (
    .clk  (clk),
    .rst  (rst),
    .ctrl (ctrl),
    .stat (stat)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      now_ticks   <= '0;
      done        <= 1'b0;
      fired       <= 1'b0;
      fired_route <= '0;
      status      <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            route_q <= route;
            prod    <= {16'b0, delay_seconds} * {16'b0, ticks_per_second};
            unique case (op)
              OP_ADD:    state <= S_DEADLINE;
              OP_CANCEL: state <= S_CANCEL;
              OP_TICK: begin
                now_ticks <= now_ticks + DL_W'(1);
                state     <= S_EXPIRE;
              end
              OP_POLL:   state <= S_EXPIRE;
              default:   state <= S_IDLE;
            endcase
          end
        end
        S_DEADLINE: begin
          deadline <= now_ticks + prod;
          state    <= S_INSERT;
        end
        S_INSERT: begin
          done        <= 1'b1;
          fired       <= 1'b0;
          fired_route <= '0;
          status      <= stat.full;
          state       <= S_IDLE;
        end
        S_CANCEL: begin
          // one matching entry leaves per cycle; finish on a clean pass
          if (!stat.any_match) begin
            done        <= 1'b1;
            fired       <= 1'b0;
            fired_route <= '0;
            status      <= 1'b0;
            state       <= S_IDLE;
          end
        end
        S_EXPIRE: begin
          done        <= 1'b1;
          fired       <= head_expired;
          fired_route <= head_expired ? stat.head.route : '0;
          status      <= 1'b0;
          state       <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

FILE: rtl/core/sto_checker.sv
`include "assert_macros.svh"

module sto_checker (
  input logic       clk,
  input logic       rst,
  input logic       start,
  input logic       busy,
  input logic       done,
  input logic       fired,
  input logic [7:0] fired_route,
  input logic       status
);

  // a result only appears once the block has gone idle
  `ASSERT_IMPLY(a_done_idle, clk, rst, done, !busy)
  // every accepted transaction raises busy once it is taken
  `ASSERT_NEXT(a_accept_busy, clk, rst, start && !busy, busy)
  // no two results back to back
  `ASSERT_NEXT(a_done_single, clk, rst, done, !done)
  // nothing fired means a zero route
  `ASSERT_IMPLY(a_route_zero, clk, rst, done && !fired, fired_route == 8'd0)
  // a dropped add never fires a timer
  `ASSERT_IMPLY(a_drop_nofire, clk, rst, done && status, !fired)

endmodule

bind sorted_timeout_queue_core sto_checker u_sto_checker (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .fired       (fired),
  .fired_route (fired_route),
  .status      (status)
);

FILE: bench/sorted_timeout_queue_core_tb.sv
module sorted_timeout_queue_core_tb import sto_pkg::*; ();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int QD = QUEUE_DEPTH_DEF;
  localparam logic [2:0] ADDR_TPS = {REG_TPS, 2'b00};

  typedef struct packed {
    timer_op_t          op;
    logic [DELAY_W-1:0] delay;
    logic [ROUTE_W-1:0] route;
  } timer_job_t;

  typedef struct packed {
    logic               fired;
    logic [ROUTE_W-1:0] fired_route;
    logic               status;
  } timer_result_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] op = '0;
  logic [DELAY_W-1:0] delay_seconds = '0;
  logic [ROUTE_W-1:0] route = '0;
  logic done;
  logic fired;
  logic [ROUTE_W-1:0] fired_route;
  logic status;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [2:0] paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic pready;

  sorted_timeout_queue_core #(.QUEUE_DEPTH(QD)) dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .op(op), .delay_seconds(delay_seconds), .route(route),
    .done(done), .fired(fired), .fired_route(fired_route), .status(status),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
    .pwdata(pwdata), .prdata(prdata), .pready(pready)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // shadow copy of the timer queue
  logic [DL_W-1:0]    sim_now;
  logic [DL_W-1:0]    slot_deadline [QD];
  logic [ROUTE_W-1:0] slot_route [QD];
  int                 slot_count;
  logic [TPS_W-1:0]   tps_setting;

  timer_job_t    job_q[$];
  timer_result_t timer_results_q[$];

  bit took_item = 1'b0;
  bit calm = 1'b0;
  int gap_left = 0;
  int err_count = 0;
  int n_taken = 0;
  int n_fired = 0;
  int n_dropped = 0;
  int n_rates = 0;

  function automatic bit wrap_before(input logic [DL_W-1:0] a, input logic [DL_W-1:0] b);
    logic [DL_W-1:0] diff;
    diff = a - b;
    return diff[DL_W-1];
  endfunction

  function automatic timer_result_t timer_queue_step(input timer_job_t job);
    timer_result_t res;
    logic [DL_W-1:0] due;
    logic [DL_W-1:0] lag;
    int pos;
    int keep;
    res = '0;
    case (job.op)
      OP_ADD: begin
        if (slot_count >= QD) begin
          res.status = 1'b1;
          n_dropped++;
        end else begin
          due = sim_now + DL_W'(job.delay) * DL_W'(tps_setting);
          pos = 0;
          while (pos < slot_count && wrap_before(slot_deadline[pos], due)) pos++;
          for (int i = slot_count; i > pos; i--) begin
            slot_deadline[i] = slot_deadline[i-1];
            slot_route[i] = slot_route[i-1];
          end
          slot_deadline[pos] = due;
          slot_route[pos] = job.route;
          slot_count++;
        end
      end
      OP_CANCEL: begin
        keep = 0;
        for (int i = 0; i < slot_count; i++) begin
          if (slot_route[i] != job.route) begin
            slot_deadline[keep] = slot_deadline[i];
            slot_route[keep] = slot_route[i];
            keep++;
          end
        end
        slot_count = keep;
      end
      default: begin
        if (job.op == OP_TICK) sim_now++;
        if (slot_count != 0) begin
          lag = sim_now - slot_deadline[0];
          // a deadline equal to now counts as expired
          if (!lag[DL_W-1]) begin
            res.fired = 1'b1;
            res.fired_route = slot_route[0];
            for (int i = 1; i < slot_count; i++) begin
              slot_deadline[i-1] = slot_deadline[i];
              slot_route[i-1] = slot_route[i];
            end
            slot_count--;
            n_fired++;
          end
        end
      end
    endcase
    return res;
  endfunction

  function automatic timer_job_t random_timer_job();
    timer_job_t job;
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 20) job.delay = '0;
    else if (pick < 65) job.delay = DELAY_W'($urandom_range(1, 6));
    else if (pick < 85) job.delay = DELAY_W'($urandom_range(0, 65535));
    else job.delay = DELAY_W'($urandom_range(65000, 65535));
    pick = $urandom_range(0, 9);
    if (pick < 8) job.route = ROUTE_W'($urandom_range(0, 7));
    else job.route = ROUTE_W'($urandom_range(0, 255));
    pick = $urandom_range(0, 99);
    if (pick < 35) job.op = OP_ADD;
    else if (pick < 70) job.op = OP_TICK;
    else if (pick < 80) job.op = OP_POLL;
    else if (pick < 90) job.op = OP_CANCEL;
    else begin
      job.op = timer_op_t'($urandom_range(0, 3));
      job.delay = DELAY_W'($urandom_range(0, 65535));
      job.route = ROUTE_W'($urandom_range(0, 255));
    end
    return job;
  endfunction

  task automatic push_job(input timer_op_t jop, input int jdelay, input int jroute);
    timer_job_t job;
    job.op = jop;
    job.delay = DELAY_W'(jdelay);
    job.route = ROUTE_W'(jroute);
    job_q.push_back(job);
  endtask

  task automatic check_field(input string what, input logic [31:0] want, input logic [31:0] got);
    if (got !== want) begin
      err_count++;
      $display("%0t: %s mismatch, expected %0h, actual %0h", $time, what, want, got);
    end
  endtask

  task automatic reg_write(input logic [2:0] addr, input logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic reg_read(input logic [2:0] addr, output logic [31:0] data);
    @(negedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= addr;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    data = prdata;
    @(negedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  task automatic check_rate();
    logic [31:0] rd;
    reg_read(ADDR_TPS, rd);
    check_field("ticks_per_second readback", 32'(tps_setting), 32'(rd[TPS_W-1:0]));
  endtask

  task automatic set_rate(input int tps);
    reg_write(ADDR_TPS, 32'(tps));
    tps_setting = TPS_W'(tps);
    n_rates++;
    check_rate();
  endtask

  task automatic wait_quiet();
    do @(negedge clk);
    while (job_q.size() != 0 || start || busy || timer_results_q.size() != 0);
  endtask

  // sender: holds each transaction until it is taken, random idle bursts between unless calm is set
  always @(negedge clk) begin : driver
    if (rst) begin
      start <= 1'b0;
    end else if (!start || took_item) begin
      if (start && took_item) begin
        job_q.delete(0);
        if (!calm && $urandom_range(0, 2) == 0) gap_left = $urandom_range(1, 15);
      end
      if (gap_left > 0) begin
        gap_left--;
        start <= 1'b0;
        op <= 2'($urandom_range(0, 3));
        delay_seconds <= DELAY_W'($urandom);
        route <= ROUTE_W'($urandom);
      end else if (job_q.size() != 0) begin
        start <= 1'b1;
        op <= job_q[0].op;
        delay_seconds <= job_q[0].delay;
        route <= job_q[0].route;
      end else begin
        start <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin : monitor
    timer_result_t want;
    timer_job_t job;
    if (rst) begin
      took_item = 1'b0;
    end else begin
      // result of the previous transaction may land on the same edge as a new accept
      if (done) begin
        if (timer_results_q.size() == 0) begin
          err_count++;
          $display("%0t: result strobe with nothing outstanding", $time);
        end else begin
          want = timer_results_q.pop_front();
          check_field("fired", 32'(want.fired), 32'(fired));
          check_field("fired_route", 32'(want.fired_route), 32'(fired_route));
          check_field("status", 32'(want.status), 32'(status));
        end
      end
      took_item = start && !busy;
      if (took_item) begin
        job.op = timer_op_t'(op);
        job.delay = delay_seconds;
        job.route = route;
        timer_results_q.push_back(timer_queue_step(job));
        n_taken++;
      end
    end
  end

  initial begin : stimulus
    int rates[5];
    sim_now = '0;
    slot_count = 0;
    tps_setting = TPS_RESET;
    repeat (11) @(posedge clk);
    @(negedge clk) rst <= 1'b0;
    check_rate();

    // empty queue, absent cancel, zero delay, far deadline
    @(posedge clk);
    push_job(OP_POLL, 0, 8'h00);
    push_job(OP_TICK, 0, 8'h00);
    push_job(OP_CANCEL, 0, 8'h5A);
    push_job(OP_ADD, 0, 8'hFF);
    push_job(OP_ADD, 65535, 8'h00);
    push_job(OP_POLL, 0, 8'h00);
    wait_quiet();

    // equal deadlines, then fill to full, drop, pop and a multi-entry cancel
    set_rate(1);
    @(posedge clk);
    push_job(OP_ADD, 2, 8'h01);
    push_job(OP_ADD, 2, 8'h02);
    push_job(OP_TICK, 0, 8'h00);
    push_job(OP_TICK, 0, 8'h00);
    for (int i = 0; i < 15; i++) push_job(OP_ADD, 7, 8'hC0 + (i % 3));
    push_job(OP_POLL, 0, 8'h00);
    push_job(OP_CANCEL, 0, 8'hC1);
    wait_quiet();

    rates[0] = 1;
    rates[1] = 65535;
    rates[2] = 3;
    rates[3] = $urandom_range(2, 65534);
    rates[4] = 1;
    for (int p = 0; p < 5; p++) begin
      wait_quiet();
      set_rate(rates[p]);
      if (p == 4) calm = 1'b1;
      @(posedge clk);
      repeat (80) job_q.push_back(random_timer_job());
    end

    wait_quiet();
    repeat (20) @(posedge clk);
    if (timer_results_q.size() != 0) begin
      err_count++;
      $display("%0t: %0d results never arrived", $time, timer_results_q.size());
    end
    $display("run covered %0d transactions over %0d rate settings", n_taken, n_rates + 1);
    $display("timers fired: %0d, adds dropped on a full queue: %0d", n_fired, n_dropped);
    if (err_count == 0) begin
      $display("** sorted_timeout_queue_core: PASSED **");
    end else begin
      $display("** sorted_timeout_queue_core: FAILED **");
    end
    $finish;
  end

  initial begin : watchdog
    #(5_000_000);
    $display("%0t: timeout", $time);
    $display("** sorted_timeout_queue_core: FAILED **");
    $finish;
  end

endmodule
